// ----- design/ttlr_pkg.sv -----
// Package: request and reply types, codes and defaults of the TTL message ring.
package ttlr_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;

    typedef enum logic [1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_READ = 2'd1,
        FUNC_MAX  = 2'd2,
        FUNC_ACK  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_DONE = 2'd0,
        KIND_MSG  = 2'd1,
        KIND_NONE = 2'd2,
        KIND_SEQ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [31:0] msg_handle;
        logic [30:0] ttl_seconds;
        logic [31:0] now_seconds;
        logic [31:0] ack_seq;
    } t_req;

    typedef struct packed {
        t_kind       reply_kind;
        logic [31:0] out_handle;
        logic [5:0]  slot_index;
        logic [31:0] seq_value;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] expiry;
    } t_slot;

endpackage

// ----- design/ttl_ack_message_ring.sv -----
// Top level: offline-message ring with TTL expiry, acknowledge and overwrite of the oldest.
// Add, max-sequence and set-ack: one reply in the cycle after acceptance, one request per cycle
// while not busy. Read: busy while it walks n slots (live minus acked, at most QUEUE_DEPTH-1)
// through the single read port of the slot memory, one slot per cycle; replies stream out
// as found, the final one (last = 1) in the first cycle with busy low.
// No stall from the receiver. Reset (synchronous): clears pointers, counters, ack, valid flags.
module ttl_ack_message_ring #(
    parameter int QUEUE_DEPTH = ttlr_pkg::QUEUE_DEPTH_DEF,
    localparam int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ttlr_pkg::t_req i_req,
    output logic           o_strobe,
    output ttlr_pkg::t_rsp o_rsp
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(QUEUE_DEPTH);

    ttlr_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [31:0]      r_dropped, n_dropped;
    logic [31:0]      r_added, n_added;
    logic [31:0]      r_acked, n_acked;
    logic [31:0]      r_now, n_now;
    logic [AW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_remain, n_remain;
    logic             r_rd_pend, n_rd_pend;
    logic [AW-1:0]    r_rd_slot, n_rd_slot;
    logic             r_pend_vld, n_pend_vld;
    logic [31:0]      r_pend_handle, n_pend_handle;
    logic [AW-1:0]    r_pend_slot, n_pend_slot;
    logic             r_strobe, n_strobe;
    ttlr_pkg::t_rsp   r_rsp, n_rsp;

    logic             wr_en;
    ttlr_pkg::t_slot  wr_data;
    logic             rd_en;
    ttlr_pkg::t_slot  rd_data;
    logic             rd_valid;

    logic [32:0]      exp_sum;
    logic [AW:0]      live_raw;
    logic [AW-1:0]    live;
    logic [31:0]      skip;
    logic [AW:0]      start_raw;
    logic             hit;

    ttlr_slot_store #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_tail),
        .i_wr_data  (wr_data),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_pos),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid)
    );

    always_comb begin
        exp_sum = {1'b0, i_req.now_seconds} + {2'b00, i_req.ttl_seconds};
        wr_data.handle = i_req.msg_handle;
        if (i_req.ttl_seconds == '0) begin
            wr_data.expiry = '0;
        end else if (exp_sum[32]) begin
            wr_data.expiry = '1;
        end else begin
            wr_data.expiry = exp_sum[31:0];
        end

        live_raw = {1'b0, r_tail} + DEPTH_W - {1'b0, r_head};
        if (live_raw >= DEPTH_W) begin
            live_raw = live_raw - DEPTH_W;
        end
        live = live_raw[AW-1:0];

        skip = '0;
        if (r_acked > r_dropped) begin
            if (r_acked > r_added) begin
                skip = 32'(live);
            end else begin
                skip = r_acked - r_dropped;
            end
            if (skip > 32'(live)) begin
                skip = 32'(live);
            end
        end
        start_raw = {1'b0, r_head} + {1'b0, skip[AW-1:0]};
        if (start_raw >= DEPTH_W) begin
            start_raw = start_raw - DEPTH_W;
        end

        hit = rd_valid && ((rd_data.expiry == '0) || (r_now < rd_data.expiry));
    end

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_dropped     = r_dropped;
        n_added       = r_added;
        n_acked       = r_acked;
        n_now         = r_now;
        n_pos         = r_pos;
        n_remain      = r_remain;
        n_rd_pend     = 1'b0;
        n_rd_slot     = r_rd_slot;
        n_pend_vld    = r_pend_vld;
        n_pend_handle = r_pend_handle;
        n_pend_slot   = r_pend_slot;
        n_strobe      = 1'b0;
        n_rsp         = '0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;

        case (r_state)
            ttlr_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_req.func)
                        ttlr_pkg::FUNC_ADD: begin
                            wr_en   = 1'b1;
                            n_added = r_added + 32'd1;
                            n_tail  = (r_tail == LAST_SLOT) ? '0 : r_tail + AW'(1);
                            if (n_tail == r_head) begin
                                n_dropped = r_dropped + 32'd1;
                                n_head    = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
                            end
                            n_strobe         = 1'b1;
                            n_rsp.reply_kind = ttlr_pkg::KIND_DONE;
                            n_rsp.last       = 1'b1;
                        end
                        ttlr_pkg::FUNC_READ: begin
                            n_now   = i_req.now_seconds;
                            n_state = ttlr_pkg::ST_SETUP;
                        end
                        ttlr_pkg::FUNC_MAX: begin
                            n_strobe         = 1'b1;
                            n_rsp.reply_kind = ttlr_pkg::KIND_SEQ;
                            n_rsp.seq_value  = r_added;
                            n_rsp.last       = 1'b1;
                        end
                        default: begin
                            n_acked          = i_req.ack_seq;
                            n_strobe         = 1'b1;
                            n_rsp.reply_kind = ttlr_pkg::KIND_DONE;
                            n_rsp.last       = 1'b1;
                        end
                    endcase
                end
            end
            ttlr_pkg::ST_SETUP: begin
                n_pos      = start_raw[AW-1:0];
                n_remain   = live - skip[AW-1:0];
                n_pend_vld = 1'b0;
                n_state    = ttlr_pkg::ST_WALK;
            end
            ttlr_pkg::ST_WALK: begin
                if (r_remain != '0) begin
                    rd_en     = 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_slot = r_pos;
                    n_pos     = (r_pos == LAST_SLOT) ? '0 : r_pos + AW'(1);
                    n_remain  = r_remain - AW'(1);
                end
                if (r_rd_pend && hit) begin
                    if (r_pend_vld) begin
                        n_strobe         = 1'b1;
                        n_rsp.reply_kind = ttlr_pkg::KIND_MSG;
                        n_rsp.out_handle = r_pend_handle;
                        n_rsp.slot_index = 6'(r_pend_slot);
                    end
                    n_pend_vld    = 1'b1;
                    n_pend_handle = rd_data.handle;
                    n_pend_slot   = r_rd_slot;
                end
                if ((r_remain == '0) && !r_rd_pend) begin
                    n_strobe   = 1'b1;
                    n_rsp.last = 1'b1;
                    if (r_pend_vld) begin
                        n_rsp.reply_kind = ttlr_pkg::KIND_MSG;
                        n_rsp.out_handle = r_pend_handle;
                        n_rsp.slot_index = 6'(r_pend_slot);
                    end else begin
                        n_rsp.reply_kind = ttlr_pkg::KIND_NONE;
                    end
                    n_state = ttlr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ttlr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ttlr_pkg::ST_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_dropped  <= '0;
            r_added    <= '0;
            r_acked    <= '0;
            r_remain   <= '0;
            r_rd_pend  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_dropped  <= n_dropped;
            r_added    <= n_added;
            r_acked    <= n_acked;
            r_remain   <= n_remain;
            r_rd_pend  <= n_rd_pend;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now         <= n_now;
        r_pos         <= n_pos;
        r_rd_slot     <= n_rd_slot;
        r_pend_handle <= n_pend_handle;
        r_pend_slot   <= n_pend_slot;
        r_rsp         <= n_rsp;
    end

    assign busy     = (r_state != ttlr_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ----- design/ttlr_slot_store.sv -----
// Slot store: handle/expiry memory with registered read and per-slot valid flags.
module ttlr_slot_store #(
    parameter int QUEUE_DEPTH = ttlr_pkg::QUEUE_DEPTH_DEF,
    localparam int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  ttlr_pkg::t_slot   i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output ttlr_pkg::t_slot   o_rd_data,
    output logic              o_rd_valid
);

    ttlr_pkg::t_slot        r_mem [QUEUE_DEPTH];
    ttlr_pkg::t_slot        r_rd_data;
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule

// ----- design/ttlr_checker.sv -----
// Checker: port-level assertions of the TTL message ring, bound to the top level.
module ttlr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input ttlr_pkg::t_req i_req,
    input logic           o_strobe,
    input ttlr_pkg::t_rsp o_rsp
);

    a_single_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.func != ttlr_pkg::FUNC_READ) |=> o_strobe && o_rsp.last)
        else $error("single-reply request did not answer next cycle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !o_strobe)
        else $error("reply without a request");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.last |-> !busy)
        else $error("final reply while still busy");

    a_non_msg_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_rsp.reply_kind != ttlr_pkg::KIND_MSG) |-> o_rsp.last)
        else $error("non-message reply without last");

    a_busy_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && (i_req.func == ttlr_pkg::FUNC_READ)))
        else $error("busy rose without a read request");

endmodule

bind ttl_ack_message_ring ttlr_checker u_ttlr_checker (.*);

// ----- sim/ttl_ack_message_ring_tb.sv -----
// Testbench: directed table and random requests against a shadow ring, replies checked in order.
module ttl_ack_message_ring_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = ttlr_pkg::QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam int CALM_TAIL = 40;

    typedef struct {
        ttlr_pkg::t_req req;
        bit             typed;
        ttlr_pkg::t_rsp want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    ttlr_pkg::t_req i_req = '0;
    logic o_strobe;
    ttlr_pkg::t_rsp o_rsp;

    logic row_typed = 1'b0;
    ttlr_pkg::t_rsp row_want = '0;

    logic [31:0] ring_handle [DEPTH];
    logic [31:0] ring_expiry [DEPTH];
    bit          ring_valid [DEPTH];
    int          ring_head;
    int          ring_tail;
    logic [31:0] drop_total;
    logic [31:0] add_total;
    logic [31:0] ack_mark;

    ttlr_pkg::t_rsp replies_due[$];
    ttlr_pkg::t_rsp fresh[$];
    ttlr_pkg::t_rsp oldest;
    t_row plan[$];

    int errors = 0;
    int replies_checked = 0;
    int messages_seen = 0;
    int adds_taken = 0;
    int reads_taken = 0;
    int requests_taken = 0;

    ttl_ack_message_ring uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic ring_step_replies(input ttlr_pkg::t_req r);
        ttlr_pkg::t_rsp rsp;
        int live;
        int skip;
        int pos;
        logic [32:0] sum;
        logic [31:0] expiry;
        logic [31:0] ahead;
        fresh.delete();
        rsp = '0;
        rsp.last = 1'b1;
        case (r.func)
            ttlr_pkg::FUNC_ADD: begin
                expiry = '0;
                if (r.ttl_seconds != '0) begin
                    sum = {1'b0, r.now_seconds} + {2'b00, r.ttl_seconds};
                    expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                add_total = add_total + 1;
                ring_handle[ring_tail] = r.msg_handle;
                ring_expiry[ring_tail] = expiry;
                ring_valid[ring_tail] = 1'b1;
                ring_tail = (ring_tail + 1) % DEPTH;
                if (ring_tail == ring_head) begin
                    drop_total = drop_total + 1;
                    ring_head = (ring_head + 1) % DEPTH;
                end
                rsp.reply_kind = ttlr_pkg::KIND_DONE;
                fresh.insert(fresh.size(), rsp);
            end
            ttlr_pkg::FUNC_READ: begin
                live = (ring_tail + DEPTH - ring_head) % DEPTH;
                skip = 0;
                if (ack_mark > drop_total) begin
                    ahead = ack_mark - drop_total;
                    if (ack_mark > add_total || ahead > 32'(live)) begin
                        skip = live;
                    end else begin
                        skip = int'(ahead);
                    end
                end
                pos = (ring_head + skip) % DEPTH;
                for (int k = 0; k < live - skip; k++) begin
                    if (ring_valid[pos] &&
                        (ring_expiry[pos] == '0 || r.now_seconds < ring_expiry[pos])) begin
                        rsp = '0;
                        rsp.reply_kind = ttlr_pkg::KIND_MSG;
                        rsp.out_handle = ring_handle[pos];
                        rsp.slot_index = 6'(pos);
                        fresh.insert(fresh.size(), rsp);
                    end
                    pos = (pos + 1) % DEPTH;
                end
                if (fresh.size() == 0) begin
                    rsp = '0;
                    rsp.reply_kind = ttlr_pkg::KIND_NONE;
                    rsp.last = 1'b1;
                    fresh.insert(fresh.size(), rsp);
                end else begin
                    rsp = fresh[fresh.size() - 1];
                    rsp.last = 1'b1;
                    fresh[fresh.size() - 1] = rsp;
                end
            end
            ttlr_pkg::FUNC_MAX: begin
                rsp.reply_kind = ttlr_pkg::KIND_SEQ;
                rsp.seq_value = add_total;
                fresh.insert(fresh.size(), rsp);
            end
            default: begin
                ack_mark = r.ack_seq;
                rsp.reply_kind = ttlr_pkg::KIND_DONE;
                fresh.insert(fresh.size(), rsp);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (replies_due.size() == 0) begin
                $error("unexpected reply: kind %0d handle %h slot %0d seq %0d last %0d",
                       o_rsp.reply_kind, o_rsp.out_handle, o_rsp.slot_index,
                       o_rsp.seq_value, o_rsp.last);
                errors++;
            end else begin
                oldest = replies_due.pop_front();
                replies_checked++;
                if (o_rsp.reply_kind == ttlr_pkg::KIND_MSG) messages_seen++;
                if (o_rsp.reply_kind !== oldest.reply_kind) begin
                    $error("reply_kind: expected %0d, got %0d",
                           oldest.reply_kind, o_rsp.reply_kind);
                    errors++;
                end
                if (o_rsp.out_handle !== oldest.out_handle) begin
                    $error("out_handle: expected %h, got %h",
                           oldest.out_handle, o_rsp.out_handle);
                    errors++;
                end
                if (o_rsp.slot_index !== oldest.slot_index) begin
                    $error("slot_index: expected %0d, got %0d",
                           oldest.slot_index, o_rsp.slot_index);
                    errors++;
                end
                if (o_rsp.seq_value !== oldest.seq_value) begin
                    $error("seq_value: expected %0d, got %0d",
                           oldest.seq_value, o_rsp.seq_value);
                    errors++;
                end
                if (o_rsp.last !== oldest.last) begin
                    $error("last: expected %0d, got %0d", oldest.last, o_rsp.last);
                    errors++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            requests_taken++;
            if (i_req.func == ttlr_pkg::FUNC_ADD) adds_taken++;
            if (i_req.func == ttlr_pkg::FUNC_READ) reads_taken++;
            ring_step_replies(i_req);
            if (row_typed) begin
                replies_due.insert(replies_due.size(), row_want);
            end else begin
                foreach (fresh[k]) replies_due.insert(replies_due.size(), fresh[k]);
            end
        end
    end

    task automatic add_row(input ttlr_pkg::t_func func, input logic [31:0] handle,
                           input logic [30:0] ttl, input logic [31:0] now,
                           input logic [31:0] ack, input bit typed,
                           input ttlr_pkg::t_kind kind, input logic [31:0] seq);
        t_row row;
        row.req = '0;
        row.req.func = func;
        row.req.msg_handle = handle;
        row.req.ttl_seconds = ttl;
        row.req.now_seconds = now;
        row.req.ack_seq = ack;
        row.typed = typed;
        row.want = '0;
        row.want.reply_kind = kind;
        row.want.seq_value = seq;
        row.want.last = 1'b1;
        plan.insert(plan.size(), row);
    endtask

    task automatic send(input ttlr_pkg::t_req req, input bit typed,
                        input ttlr_pkg::t_rsp want);
        start <= 1'b1;
        i_req <= req;
        row_typed <= typed;
        row_want <= want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        ttlr_pkg::t_req req;
        int gap;
        int pick;
        int waited;
        bit idle_on;
        logic [31:0] wall;

        for (int k = 0; k < DEPTH; k++) begin
            ring_handle[k] = '0;
            ring_expiry[k] = '0;
            ring_valid[k] = 1'b0;
        end
        ring_head = 0;
        ring_tail = 0;
        drop_total = '0;
        add_total = '0;
        ack_mark = '0;

        add_row(ttlr_pkg::FUNC_READ, 32'h0, 31'h0, 32'h0, 32'h0,
                1'b1, ttlr_pkg::KIND_NONE, 32'd0);
        add_row(ttlr_pkg::FUNC_MAX, 32'h0, 31'h0, 32'h0, 32'h0,
                1'b1, ttlr_pkg::KIND_SEQ, 32'd0);
        add_row(ttlr_pkg::FUNC_ADD, 32'h0, 31'h0, 32'h0, 32'h0,
                1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_ADD, 32'hA5A5_A5A5, 31'd10, 32'd100, 32'h0,
                1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_ADD, 32'h5A5A_5A5A, 31'd1, 32'hFFFF_FFFE, 32'h0,
                1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_READ, 32'h0, 31'h0, 32'd0, 32'h0,
                1'b0, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_READ, 32'h0, 31'h0, 32'd109, 32'h0,
                1'b0, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_READ, 32'h0, 31'h0, 32'd110, 32'h0,
                1'b0, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_READ, 32'h0, 31'h0, 32'hFFFF_FFFF, 32'h0,
                1'b0, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_MAX, 32'h0, 31'h0, 32'h0, 32'h0,
                1'b1, ttlr_pkg::KIND_SEQ, 32'd4);
        add_row(ttlr_pkg::FUNC_ACK, 32'h0, 31'h0, 32'h0, 32'd2,
                1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_READ, 32'h0, 31'h0, 32'd0, 32'h0,
                1'b0, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_ACK, 32'h0, 31'h0, 32'h0, 32'd4,
                1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_READ, 32'h0, 31'h0, 32'd0, 32'h0,
                1'b1, ttlr_pkg::KIND_NONE, 32'd0);
        add_row(ttlr_pkg::FUNC_ACK, 32'h0, 31'h0, 32'h0, 32'd5,
                1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_READ, 32'h0, 31'h0, 32'd0, 32'h0,
                1'b1, ttlr_pkg::KIND_NONE, 32'd0);
        add_row(ttlr_pkg::FUNC_ACK, 32'h0, 31'h0, 32'h0, 32'hFFFF_FFFF,
                1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_READ, 32'h0, 31'h0, 32'd0, 32'h0,
                1'b1, ttlr_pkg::KIND_NONE, 32'd0);
        add_row(ttlr_pkg::FUNC_ACK, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_ADD, 32'h1234_5678, 31'h5555_5555, 32'hAAAA_AAAA,
                32'hFFFF_FFFF, 1'b1, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_READ, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'd50, 32'hFFFF_FFFF,
                1'b0, ttlr_pkg::KIND_DONE, 32'd0);
        add_row(ttlr_pkg::FUNC_MAX, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b1, ttlr_pkg::KIND_SEQ, 32'd5);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            send(plan[k].req, plan[k].typed, plan[k].want);
            if (k % 3 == 1) begin
                gap = $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        drain();

        wall = 32'd1000;
        idle_on = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (n >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
            if (n == RANDOM_ITEMS / 2) drain();

            wall = wall + $urandom_range(0, 15);
            req.msg_handle = $urandom;
            req.ack_seq = $urandom;
            req.now_seconds = ($urandom_range(0, 19) == 0) ? $urandom : wall;
            pick = $urandom_range(0, 9);
            if (pick < 2) req.ttl_seconds = '0;
            else if (pick < 8) req.ttl_seconds = 31'($urandom_range(1, 80));
            else if (pick == 8) req.ttl_seconds = 31'($urandom);
            else req.ttl_seconds = 31'h7FFF_FFFF;

            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                req.func = ttlr_pkg::FUNC_ADD;
            end else if (pick < 75) begin
                req.func = ttlr_pkg::FUNC_READ;
            end else if (pick < 85) begin
                req.func = ttlr_pkg::FUNC_MAX;
            end else begin
                req.func = ttlr_pkg::FUNC_ACK;
                pick = $urandom_range(0, 9);
                if (pick < 7) req.ack_seq = drop_total + $urandom_range(0, add_total - drop_total);
                else if (pick == 7) req.ack_seq = $urandom_range(0, drop_total);
                else if (pick == 8) req.ack_seq = add_total + $urandom_range(1, 3);
            end

            send(req, 1'b0, '0);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        start <= 1'b0;
        waited = 0;
        while (replies_due.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * DEPTH) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            $error("%0d replies never arrived", replies_due.size());
            errors++;
        end

        $display("Run: %0d requests (%0d adds, %0d reads), %0d replies checked, %0d messages.",
                 requests_taken, adds_taken, reads_taken, replies_checked, messages_seen);
        $display("Ring wrapped with %0d oldest entries overwritten; final ack mark %0d.",
                 drop_total, ack_mark);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
design/ttlr_pkg.sv
design/ttlr_slot_store.sv
design/ttl_ack_message_ring.sv
design/ttlr_checker.sv
sim/ttl_ack_message_ring_tb.sv
